@@ hdl/kdp_pkg.sv @@
package kdp_pkg;

  localparam int unsigned ColW = 6;

  localparam logic [7:0] Flag       = 8'h80;
  localparam logic [7:0] PageHi     = 8'hD0;
  localparam logic [7:0] RegFirst   = 8'h10;
  localparam logic [7:0] RegLast    = 8'h13;
  localparam logic [7:0] KeyUscore  = 8'h5F;
  localparam logic [7:0] KeyBksp    = 8'h08;
  localparam logic [7:0] KeyLf      = 8'h0A;
  localparam logic [7:0] KeyCr      = 8'h0D;
  localparam logic [7:0] LowerA     = 8'h61;
  localparam logic [7:0] LowerZ     = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'd32;

  localparam logic [6:0] ChCr       = 7'h0D;
  localparam logic [6:0] ChNl       = 7'h0A;
  localparam logic [6:0] ChBksp     = 7'h08;
  localparam logic [6:0] ChUscore   = 7'h5F;
  localparam logic [6:0] ChDel      = 7'h7F;
  localparam logic [6:0] ChCtrlTop  = 7'h1F;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_KEY   = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEL_KEY_DATA  = 2'd0,
    SEL_KEY_CTRL  = 2'd1,
    SEL_DISP_DATA = 2'd2,
    SEL_DISP_CTRL = 2'd3
  } sel_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       register_hit;
    logic       key_accepted;
    logic       char_valid;
    logic [6:0] char_out;
    logic       last_result;
  } res_t;

  function automatic logic [7:0] key_xlate(input logic [7:0] code, input logic map_lf);
    logic [7:0] c;
    c = code;
    if (c == KeyBksp) c = KeyUscore;
    if (map_lf && c == KeyLf) c = KeyCr;
    if (c >= LowerA && c <= LowerZ) c = c - CaseOffset;
    return c;
  endfunction

  function automatic logic disp_printable(input logic [6:0] c);
    return (c > ChCtrlTop || c == ChBksp) && c != ChDel;
  endfunction

endpackage

@@ hdl/kdp_if.sv @@
interface kdp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  key_code;

  modport source (output valid, op, address, write_data, key_code, input ready);
  modport sink   (input valid, op, address, write_data, key_code, output ready);
endinterface

interface kdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       register_hit;
  logic       key_accepted;
  logic       char_valid;
  logic [6:0] char_out;
  logic       last_result;

  modport source (output valid, read_data, register_hit, key_accepted, char_valid,
                  char_out, last_result, input ready);
  modport sink   (input valid, read_data, register_hit, key_accepted, char_valid,
                  char_out, last_result, output ready);
endinterface

interface kdp_cfg_if;
  logic valid;
  logic ready;
  logic map_linefeed;

  modport source (output valid, map_linefeed, input ready);
  modport sink   (input valid, map_linefeed, output ready);
endinterface

@@ hdl/keyboard_display_pia.sv @@
// Keyboard/display register block at 0xD010-0xD013.
// Channels: in_i takes items (op, address, write_data, key_code); out_o
// returns results; cfg_i writes map_linefeed (always ready, reset value 1).
// Each input item is handled in the cycle it transfers: registers update at
// that edge, and so does the output register, which then holds the result.
// Bus, key and idle tick items give one result; a tick that prints and ends
// the line gives two, the second a forced newline with last_result set.
// Throughput: one item per clock while the receiver takes every result;
// a two-result tick holds the input until its first result is taken, set by
// the single output register plus one pending-newline flag.
// Reset clears all four registers, the column count and the output stage.
// When out_o stalls, the result stays in the output register and in_i.ready
// drops until it can be replaced in the same cycle it is taken.
module keyboard_display_pia #(
  parameter int unsigned LINE_WIDTH = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kdp_in_if.sink    in_i,
  kdp_out_if.source out_o,
  kdp_cfg_if.sink   cfg_i
);

  logic [7:0] key_data_q, key_data_d;
  logic [7:0] key_ctrl_q, key_ctrl_d;
  logic [7:0] disp_data_q, disp_data_d;
  logic [7:0] disp_ctrl_q, disp_ctrl_d;
  logic [kdp_pkg::ColW-1:0] col_q, col_d, col_mid;
  logic map_lf_q;

  kdp_pkg::res_t res_q, res_d, nl_res;
  logic out_valid_q, nl_pend_q, two_d;
  logic in_xfer, out_xfer, hit;
  logic [6:0] ch;
  logic emit;
  kdp_pkg::sel_e sel;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready = !out_valid_q || (out_o.ready && !nl_pend_q);
  assign cfg_i.ready = 1'b1;

  assign hit = in_i.address[15:8] == kdp_pkg::PageHi &&
               in_i.address[7:0] >= kdp_pkg::RegFirst &&
               in_i.address[7:0] <= kdp_pkg::RegLast;
  assign sel = kdp_pkg::sel_e'(in_i.address[1:0]);

  always_comb begin
    nl_res = '0;
    nl_res.char_valid  = 1'b1;
    nl_res.char_out    = kdp_pkg::ChNl;
    nl_res.last_result = 1'b1;
  end

  always_comb begin
    key_data_d  = key_data_q;
    key_ctrl_d  = key_ctrl_q;
    disp_data_d = disp_data_q;
    disp_ctrl_d = disp_ctrl_q;
    col_d       = col_q;
    col_mid     = col_q;
    res_d       = '0;
    res_d.last_result = 1'b1;
    two_d = 1'b0;
    ch    = '0;
    emit  = 1'b0;
    unique case (kdp_pkg::op_e'(in_i.op))
      kdp_pkg::OP_READ: begin
        res_d.register_hit = hit;
        if (hit) begin
          unique case (sel)
            kdp_pkg::SEL_KEY_DATA: begin
              res_d.read_data = key_data_q;
              key_ctrl_d = key_ctrl_q & ~kdp_pkg::Flag;
            end
            kdp_pkg::SEL_KEY_CTRL:  res_d.read_data = key_ctrl_q;
            kdp_pkg::SEL_DISP_DATA: res_d.read_data = disp_data_q;
            kdp_pkg::SEL_DISP_CTRL: res_d.read_data = disp_ctrl_q;
            default: ;
          endcase
        end
      end
      kdp_pkg::OP_WRITE: begin
        res_d.register_hit = hit;
        if (hit) begin
          unique case (sel)
            kdp_pkg::SEL_KEY_DATA:  key_data_d  = in_i.write_data;
            kdp_pkg::SEL_KEY_CTRL:  key_ctrl_d  = in_i.write_data;
            kdp_pkg::SEL_DISP_DATA: disp_data_d = in_i.write_data | kdp_pkg::Flag;
            kdp_pkg::SEL_DISP_CTRL: disp_ctrl_d = in_i.write_data;
            default: ;
          endcase
        end
      end
      kdp_pkg::OP_KEY: begin
        if (!key_ctrl_q[7]) begin
          res_d.key_accepted = 1'b1;
          if (in_i.key_code != kdp_pkg::KeyUscore) begin
            key_data_d = kdp_pkg::key_xlate(in_i.key_code, map_lf_q) | kdp_pkg::Flag;
            key_ctrl_d = key_ctrl_q | kdp_pkg::Flag;
          end
        end
      end
      kdp_pkg::OP_TICK: begin
        if (disp_data_q[7]) begin
          if (disp_data_q[6:0] == kdp_pkg::ChCr) begin
            emit    = 1'b1;
            ch      = kdp_pkg::ChNl;
            col_mid = '0;
          end else if (kdp_pkg::disp_printable(disp_data_q[6:0])) begin
            emit    = 1'b1;
            ch      = (disp_data_q[6:0] == kdp_pkg::ChUscore) ? kdp_pkg::ChBksp
                                                               : disp_data_q[6:0];
            col_mid = col_q + 1'b1;
          end
          disp_data_d = ~disp_data_q;
          col_d = col_mid;
          if (col_mid >= kdp_pkg::ColW'(LINE_WIDTH)) begin
            col_d = '0;
            if (emit) begin
              two_d = 1'b1;
            end else begin
              emit = 1'b1;
              ch   = kdp_pkg::ChNl;
            end
          end
        end
        res_d.char_valid  = emit;
        res_d.char_out    = ch;
        res_d.last_result = !two_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_data_q  <= '0;
      key_ctrl_q  <= '0;
      disp_data_q <= '0;
      disp_ctrl_q <= '0;
      col_q       <= '0;
      map_lf_q    <= 1'b1;
      out_valid_q <= 1'b0;
      nl_pend_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        map_lf_q <= cfg_i.map_linefeed;
      end
      if (in_xfer) begin
        key_data_q  <= key_data_d;
        key_ctrl_q  <= key_ctrl_d;
        disp_data_q <= disp_data_d;
        disp_ctrl_q <= disp_ctrl_d;
        col_q       <= col_d;
        out_valid_q <= 1'b1;
        nl_pend_q   <= two_d;
      end else if (out_xfer) begin
        if (nl_pend_q) begin
          nl_pend_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end else if (out_xfer && nl_pend_q) begin
      res_q <= nl_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = res_q.read_data;
  assign out_o.register_hit = res_q.register_hit;
  assign out_o.key_accepted = res_q.key_accepted;
  assign out_o.char_valid   = res_q.char_valid;
  assign out_o.char_out     = res_q.char_out;
  assign out_o.last_result  = res_q.last_result;

  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_pend_q |-> out_valid_q) else $error("newline pending without output");

  a_in_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q) else $error("accepted item left no result");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_pend_q |-> !res_q.last_result) else $error("first of two results marked last");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < kdp_pkg::ColW'(LINE_WIDTH)) else $error("column count past line width");

endmodule
